[hdl/eeprom_atom_table_checker_assert.svh]
// Assertion macros for the EEPROM atom table checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef EEPROM_ATOM_TABLE_CHECKER_ASSERT_SVH
`define EEPROM_ATOM_TABLE_CHECKER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define EATC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define EATC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/eatc_pkg.sv]
// Shared types, constants and the CRC helper of the EEPROM atom table checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eatc_pkg;

    localparam int unsigned SIGNATURE_BYTES = 4;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW = 2;
    localparam int unsigned FIFO_CW = 3;
    localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;

    localparam logic CFG_WANTED_TYPE = 1'b0;
    localparam logic CFG_SIGNATURE_WORD = 1'b1;

    typedef enum logic [2:0] {
        KIND_OK       = 3'd0,
        KIND_BAD_SIG  = 3'd1,
        KIND_CRC_ERR  = 3'd2,
        KIND_OVERFLOW = 3'd3,
        KIND_DONE     = 3'd4,
        KIND_BAD_LEN  = 3'd5
    } kind_t;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_IMAGE_HDR = 5'b00010,
        PH_ATOM_HDR  = 5'b00100,
        PH_ATOM_DATA = 5'b01000,
        PH_STOPPED   = 5'b10000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] atom_type;
        logic [15:0] atom_count;
        logic [31:0] data_length;
        logic [15:0] computed_crc;
        logic [15:0] stored_crc;
        logic        type_match;
        logic        final_res;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY_REFLECTED;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/eeprom_atom_table_checker.sv]
// An accepted byte is held in the stage register and decoded from there; its results are
// written into the result queue, whose head drives the outputs. Throughput: one byte
// per cycle, held back only while the four-entry result queue has fewer than two free slots.
// Reset (rst_n, asynchronous, active low) empties the queue, clears the configuration and walk
// registers to zero and leaves the walk idle until a first byte arrives.
// Depends on eatc_pkg and eeprom_atom_table_checker_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

module eeprom_atom_table_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_enable,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       result_kind,
    output logic [15:0]      atom_type,
    output logic [15:0]      atom_count,
    output logic [31:0]      data_length,
    output logic [15:0]      computed_crc,
    output logic [15:0]      stored_crc,
    output logic             type_match,
    output logic             final_res
);

    import eatc_pkg::*;

    localparam logic [31:0] SIG_LEN = 32'(SIGNATURE_BYTES);
    localparam logic [FIFO_CW-1:0] ROOM_LIMIT = FIFO_CW'(FIFO_DEPTH - 2);

    logic [15:0] wanted_type_reg;
    logic [31:0] signature_word_reg;

    logic        stage_valid_reg;
    logic [7:0]  stage_byte_reg;
    logic        stage_first_reg;
    logic        stage_go;
    logic        in_accept;

    phase_t      phase_reg, phase_next;
    logic [31:0] bis_reg, bis_next;
    logic [31:0] pos_reg, pos_next;
    logic        sat_reg, sat_next;
    logic [31:0] total_reg, total_next;
    logic [15:0] atoms_reg, atoms_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  slow_reg, slow_next;

    result_t     res0, res1;
    logic        push0, push1;
    logic [1:0]  push_n;
    logic        pop;

    result_t            fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] fifo_count_reg;
    result_t            head;

    logic [31:0] off;
    logic [31:0] len_m2;
    logic [15:0] stored;
    logic [15:0] atoms_dec;
    logic        over;
    logic        active;
    phase_t      ph;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_type_reg    <= '0;
            signature_word_reg <= '0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                CFG_WANTED_TYPE:    wanted_type_reg    <= cfg_data[15:0];
                CFG_SIGNATURE_WORD: signature_word_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign stage_go  = stage_valid_reg && (fifo_count_reg <= ROOM_LIMIT);
    assign in_stall  = stage_valid_reg && !stage_go;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (stage_go)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_byte_reg  <= data_byte;
            stage_first_reg <= first_byte;
        end
    end

    always_comb
    begin
        active = stage_first_reg || (phase_reg == PH_IMAGE_HDR)
                 || (phase_reg == PH_ATOM_HDR) || (phase_reg == PH_ATOM_DATA);
        ph = stage_first_reg ? PH_IMAGE_HDR : phase_reg;

        phase_next = phase_reg;
        bis_next   = bis_reg;
        pos_next   = pos_reg;
        sat_next   = sat_reg;
        total_next = total_reg;
        atoms_next = atoms_reg;
        type_next  = type_reg;
        count_next = count_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        slow_next  = slow_reg;
        res0       = '0;
        res1       = '0;
        push0      = 1'b0;
        push1      = 1'b0;
        off        = '0;
        len_m2     = '0;
        stored     = '0;
        atoms_dec  = '0;
        over       = 1'b0;

        if (stage_go && active)
        begin
            if (stage_first_reg)
            begin
                bis_next   = '0;
                pos_next   = '0;
                sat_next   = 1'b0;
                total_next = '0;
                atoms_next = '0;
                type_next  = '0;
                count_next = '0;
                len_next   = '0;
                crc_next   = '0;
                slow_next  = '0;
            end
            phase_next = ph;

            if (pos_next == 32'hFFFF_FFFF)
            begin
                sat_next = 1'b1;
            end
            else
            begin
                pos_next = pos_next + 32'd1;
            end

            unique case (ph)
                PH_IMAGE_HDR:
                begin
                    off = bis_next - SIG_LEN;
                    if (bis_next < SIG_LEN)
                    begin
                        if (stage_byte_reg
                            != signature_word_reg[{bis_next[1:0], 3'b000} +: 8])
                        begin
                            res0.kind      = KIND_BAD_SIG;
                            res0.final_res = 1'b1;
                            push0          = 1'b1;
                            phase_next     = PH_STOPPED;
                        end
                    end
                    else if (off == 32'd2)
                    begin
                        atoms_next[7:0] = stage_byte_reg;
                    end
                    else if (off == 32'd3)
                    begin
                        atoms_next[15:8] = stage_byte_reg;
                    end
                    else if (off >= 32'd4 && off <= 32'd7)
                    begin
                        total_next[{off[1:0], 3'b000} +: 8] = stage_byte_reg;
                    end

                    if (!push0)
                    begin
                        if (bis_next == SIG_LEN + 32'd7)
                        begin
                            bis_next = '0;
                            if (atoms_next == 16'd0)
                            begin
                                res0.kind      = KIND_DONE;
                                res0.final_res = 1'b1;
                                push0          = 1'b1;
                                phase_next     = PH_STOPPED;
                            end
                            else
                            begin
                                crc_next   = '0;
                                phase_next = PH_ATOM_HDR;
                            end
                        end
                        else
                        begin
                            bis_next = bis_next + 32'd1;
                        end
                    end
                end
                PH_ATOM_HDR:
                begin
                    crc_next = crc_byte(crc_next, stage_byte_reg);
                    if (bis_next < 32'd2)
                    begin
                        type_next[{bis_next[0], 3'b000} +: 8] = stage_byte_reg;
                    end
                    else if (bis_next < 32'd4)
                    begin
                        count_next[{bis_next[0], 3'b000} +: 8] = stage_byte_reg;
                    end
                    else
                    begin
                        len_next[{bis_next[1:0], 3'b000} +: 8] = stage_byte_reg;
                    end
                    if (bis_next >= 32'd7)
                    begin
                        bis_next = '0;
                        if (len_next < 32'd2)
                        begin
                            res0.kind        = KIND_BAD_LEN;
                            res0.atom_type   = type_next;
                            res0.atom_count  = count_next;
                            res0.data_length = len_next;
                            res0.final_res   = 1'b1;
                            push0            = 1'b1;
                            phase_next       = PH_STOPPED;
                        end
                        else
                        begin
                            phase_next = PH_ATOM_DATA;
                        end
                    end
                    else
                    begin
                        bis_next = bis_next + 32'd1;
                    end
                end
                PH_ATOM_DATA:
                begin
                    len_m2 = len_next - 32'd2;
                    if (bis_next < len_m2)
                    begin
                        crc_next = crc_byte(crc_next, stage_byte_reg);
                        bis_next = bis_next + 32'd1;
                    end
                    else if (bis_next == len_m2)
                    begin
                        slow_next = stage_byte_reg;
                        bis_next  = bis_next + 32'd1;
                    end
                    else
                    begin
                        stored            = {stage_byte_reg, slow_next};
                        res0.atom_type    = type_next;
                        res0.atom_count   = count_next;
                        res0.data_length  = len_next;
                        res0.computed_crc = crc_next;
                        res0.stored_crc   = stored;
                        push0             = 1'b1;
                        if (stored != crc_next)
                        begin
                            res0.kind      = KIND_CRC_ERR;
                            res0.final_res = 1'b1;
                            phase_next     = PH_STOPPED;
                        end
                        else
                        begin
                            atoms_dec       = atoms_next - 16'd1;
                            atoms_next      = atoms_dec;
                            over            = sat_next || (pos_next > total_next);
                            res0.kind       = KIND_OK;
                            res0.type_match = (type_next == wanted_type_reg);
                            if (over || atoms_dec == 16'd0)
                            begin
                                res1.kind      = over ? KIND_OVERFLOW : KIND_DONE;
                                res1.final_res = 1'b1;
                                push1          = 1'b1;
                                phase_next     = PH_STOPPED;
                            end
                            else
                            begin
                                bis_next   = '0;
                                crc_next   = '0;
                                phase_next = PH_ATOM_HDR;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bis_reg   <= '0;
            pos_reg   <= '0;
            sat_reg   <= 1'b0;
            total_reg <= '0;
            atoms_reg <= '0;
            type_reg  <= '0;
            count_reg <= '0;
            len_reg   <= '0;
            crc_reg   <= '0;
            slow_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            bis_reg   <= bis_next;
            pos_reg   <= pos_next;
            sat_reg   <= sat_next;
            total_reg <= total_next;
            atoms_reg <= atoms_next;
            type_reg  <= type_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            slow_reg  <= slow_next;
        end
    end

    // Result queue: up to two entries written per cycle, one read.
    assign push_n    = {1'b0, push0} + {1'b0, push1};
    assign out_valid = (fifo_count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (push1)
        begin
            fifo_mem[wr_ptr_reg + FIFO_AW'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_reg + FIFO_AW'(push_n);
            rd_ptr_reg     <= rd_ptr_reg + FIFO_AW'(pop);
            fifo_count_reg <= fifo_count_reg + FIFO_CW'(push_n) - FIFO_CW'(pop);
        end
    end

    assign result_kind  = head.kind;
    assign atom_type    = head.atom_type;
    assign atom_count   = head.atom_count;
    assign data_length  = head.data_length;
    assign computed_crc = head.computed_crc;
    assign stored_crc   = head.stored_crc;
    assign type_match   = head.type_match;
    assign final_res    = head.final_res;

`include "eeprom_atom_table_checker_assert.svh"

    `EATC_ASSERT_IMP(a_fifo_bound, 1'b1, fifo_count_reg <= FIFO_CW'(FIFO_DEPTH))
    `EATC_ASSERT_IMP(a_second_is_final, push1, push0 && res1.final_res && !res0.final_res)
    `EATC_ASSERT_NEXT(a_final_stops, push0 && (res0.final_res || push1), phase_reg == PH_STOPPED)
    `EATC_ASSERT_IMP(a_match_only_ok, push0 && res0.type_match, res0.kind == KIND_OK)

endmodule

`default_nettype wire

[test/eeprom_atom_table_checker_tb.sv]
// Self-checking testbench for eeprom_atom_table_checker: streams EEPROM images through the
// byte channel and compares every result transfer against a cycle-free model of the walk.
// Depends on eatc_pkg and the eeprom_atom_table_checker RTL.
`timescale 1ns / 1ps

module eeprom_atom_table_checker_tb;

    import eatc_pkg::*;

    localparam logic [15:0] ARC_POLY_REV = 16'hA001;
    localparam int DRAIN_PAD = 6;
    localparam int PHASE_BYTES = 670;
    localparam int HOLD_START = 1600;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] value;
        logic       first;
    } image_byte_t;

    typedef enum int {
        SHAPE_CLEAN,
        SHAPE_OVERFLOW,
        SHAPE_BAD_CRC,
        SHAPE_SHORT_ATOM,
        SHAPE_BAD_SIGNATURE,
        SHAPE_EMPTY,
        SHAPE_CUT_SHORT,
        SHAPE_EXTRA_ATOMS,
        SHAPE_HUGE_ATOM,
        SHAPE_NOISE
    } image_shape_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_enable = 1'b0;
    logic        cfg_index = CFG_WANTED_TYPE;
    logic [31:0] cfg_data = 32'h0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        first_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  result_kind;
    logic [15:0] atom_type;
    logic [15:0] atom_count;
    logic [31:0] data_length;
    logic [15:0] computed_crc;
    logic [15:0] stored_crc;
    logic        type_match;
    logic        final_res;

    image_byte_t pending_bytes[$];
    result_t     expected_results[$];
    int          queued_total = 0;
    int          bytes_accepted = 0;
    int          error_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_idle_pct = 0;
    logic        long_hold = 1'b0;

    logic [15:0] want_type = 16'h0;
    logic [31:0] sig_word = 32'h0;

    phase_t      walk_phase = PH_IDLE;
    logic [31:0] sect_idx = 32'h0;
    logic [31:0] img_pos = 32'h0;
    logic        img_pos_sat = 1'b0;
    logic [31:0] table_len = 32'h0;
    logic [15:0] atoms_remaining = 16'h0;
    logic [15:0] hdr_type = 16'h0;
    logic [15:0] hdr_count = 16'h0;
    logic [31:0] hdr_len = 32'h0;
    logic [15:0] crc_acc = 16'h0;
    logic [7:0]  crc_low_byte = 8'h0;

    eeprom_atom_table_checker DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_enable(cfg_write_enable),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .first_byte(first_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_kind(result_kind),
        .atom_type(atom_type),
        .atom_count(atom_count),
        .data_length(data_length),
        .computed_crc(computed_crc),
        .stored_crc(stored_crc),
        .type_match(type_match),
        .final_res(final_res)
    );

    function automatic logic [15:0] crc16_arc_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int n = 0; n < 8; n++)
        begin
            fb = r[0] ^ d[n];
            r = r >> 1;
            if (fb)
            begin
                r = r ^ ARC_POLY_REV;
            end
        end
        return r;
    endfunction

    function automatic void add_expected_result(input kind_t k, input logic [15:0] t,
                                                input logic [15:0] c, input logic [31:0] len,
                                                input logic [15:0] ccrc, input logic [15:0] scrc,
                                                input logic m, input logic f);
        result_t r;
        r.kind = k;
        r.atom_type = t;
        r.atom_count = c;
        r.data_length = len;
        r.computed_crc = ccrc;
        r.stored_crc = scrc;
        r.type_match = m;
        r.final_res = f;
        expected_results.push_back(r);
    endfunction

    task automatic walk_image_byte(input logic [7:0] b, input logic fb);
        logic [31:0] idx;
        logic [31:0] off;
        logic [15:0] stored;
        logic        over;
        if (fb)
        begin
            sect_idx = 32'h0;
            img_pos = 32'h0;
            img_pos_sat = 1'b0;
            table_len = 32'h0;
            atoms_remaining = 16'h0;
            hdr_type = 16'h0;
            hdr_count = 16'h0;
            hdr_len = 32'h0;
            crc_acc = 16'h0;
            crc_low_byte = 8'h0;
            walk_phase = PH_IMAGE_HDR;
        end
        else if (walk_phase != PH_IMAGE_HDR && walk_phase != PH_ATOM_HDR
                 && walk_phase != PH_ATOM_DATA)
        begin
            return;
        end
        if (img_pos == 32'hFFFF_FFFF)
        begin
            img_pos_sat = 1'b1;
        end
        else
        begin
            img_pos = img_pos + 32'd1;
        end
        idx = sect_idx;
        case (walk_phase)
            PH_IMAGE_HDR:
            begin
                if (idx < SIGNATURE_BYTES)
                begin
                    if (b != sig_word[8 * idx[1:0] +: 8])
                    begin
                        add_expected_result(KIND_BAD_SIG, '0, '0, '0, '0, '0, 1'b0, 1'b1);
                        walk_phase = PH_STOPPED;
                        return;
                    end
                end
                else
                begin
                    off = idx - SIGNATURE_BYTES;
                    if (off == 2 || off == 3)
                    begin
                        atoms_remaining[8 * (off - 2) +: 8] = b;
                    end
                    else if (off >= 4 && off <= 7)
                    begin
                        table_len[8 * (off - 4) +: 8] = b;
                    end
                end
                if (idx == SIGNATURE_BYTES + 7)
                begin
                    sect_idx = 32'h0;
                    if (atoms_remaining == 16'h0)
                    begin
                        add_expected_result(KIND_DONE, '0, '0, '0, '0, '0, 1'b0, 1'b1);
                        walk_phase = PH_STOPPED;
                        return;
                    end
                    crc_acc = 16'h0;
                    walk_phase = PH_ATOM_HDR;
                end
                else
                begin
                    sect_idx = idx + 32'd1;
                end
            end
            PH_ATOM_HDR:
            begin
                crc_acc = crc16_arc_step(crc_acc, b);
                if (idx < 2)
                begin
                    hdr_type[8 * idx +: 8] = b;
                end
                else if (idx < 4)
                begin
                    hdr_count[8 * (idx - 2) +: 8] = b;
                end
                else
                begin
                    hdr_len[8 * ((idx - 4) & 3) +: 8] = b;
                end
                if (idx >= 7)
                begin
                    sect_idx = 32'h0;
                    if (hdr_len < 2)
                    begin
                        add_expected_result(KIND_BAD_LEN, hdr_type, hdr_count, hdr_len,
                                            '0, '0, 1'b0, 1'b1);
                        walk_phase = PH_STOPPED;
                        return;
                    end
                    walk_phase = PH_ATOM_DATA;
                end
                else
                begin
                    sect_idx = idx + 32'd1;
                end
            end
            PH_ATOM_DATA:
            begin
                if (idx < hdr_len - 32'd2)
                begin
                    crc_acc = crc16_arc_step(crc_acc, b);
                    sect_idx = idx + 32'd1;
                end
                else if (idx == hdr_len - 32'd2)
                begin
                    crc_low_byte = b;
                    sect_idx = idx + 32'd1;
                end
                else
                begin
                    stored = {b, crc_low_byte};
                    if (stored != crc_acc)
                    begin
                        add_expected_result(KIND_CRC_ERR, hdr_type, hdr_count, hdr_len,
                                            crc_acc, stored, 1'b0, 1'b1);
                        walk_phase = PH_STOPPED;
                        return;
                    end
                    atoms_remaining = atoms_remaining - 16'd1;
                    over = img_pos_sat || (img_pos > table_len);
                    add_expected_result(KIND_OK, hdr_type, hdr_count, hdr_len, crc_acc, stored,
                                        hdr_type == want_type, 1'b0);
                    if (over || atoms_remaining == 16'h0)
                    begin
                        add_expected_result(over ? KIND_OVERFLOW : KIND_DONE,
                                            '0, '0, '0, '0, '0, 1'b0, 1'b1);
                        walk_phase = PH_STOPPED;
                    end
                    else
                    begin
                        sect_idx = 32'h0;
                        crc_acc = 16'h0;
                        walk_phase = PH_ATOM_HDR;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic void push_item(input logic [7:0] b, input logic fb);
        image_byte_t item;
        item.value = b;
        item.first = fb;
        pending_bytes.push_back(item);
        queued_total++;
    endfunction

    task automatic queue_random_image();
        logic [7:0]   body[$];
        logic [63:0]  atom_hdr;
        logic [15:0]  crc;
        logic [15:0]  a_type;
        logic [15:0]  a_count;
        logic [31:0]  a_len;
        logic [31:0]  total;
        logic [15:0]  count_field;
        logic [7:0]   d;
        int unsigned  roll;
        int           n_atoms;
        int           bad_atom;
        int           bad_pos;
        int           n;
        image_shape_t shape;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            shape = SHAPE_CLEAN;
        else if (roll < 55)
            shape = SHAPE_OVERFLOW;
        else if (roll < 63)
            shape = SHAPE_BAD_CRC;
        else if (roll < 70)
            shape = SHAPE_SHORT_ATOM;
        else if (roll < 75)
            shape = SHAPE_BAD_SIGNATURE;
        else if (roll < 79)
            shape = SHAPE_EMPTY;
        else if (roll < 84)
            shape = SHAPE_CUT_SHORT;
        else if (roll < 88)
            shape = SHAPE_EXTRA_ATOMS;
        else if (roll < 92)
            shape = SHAPE_HUGE_ATOM;
        else
            shape = SHAPE_NOISE;

        if (shape == SHAPE_NOISE)
        begin
            n = $urandom_range(3, 20);
            repeat (n) push_item(8'($urandom), $urandom_range(0, 7) == 0);
            return;
        end

        n_atoms = (shape == SHAPE_EXTRA_ATOMS) ? $urandom_range(2, 4) : $urandom_range(1, 4);
        bad_atom = $urandom_range(0, n_atoms - 1);
        bad_pos = $urandom_range(0, SIGNATURE_BYTES - 1);
        count_field = 16'(n_atoms);
        if (shape == SHAPE_EMPTY)
        begin
            n_atoms = 0;
            count_field = 16'h0;
        end
        else if (shape == SHAPE_CUT_SHORT)
        begin
            count_field = 16'(n_atoms + $urandom_range(1, 3));
        end
        else if (shape == SHAPE_EXTRA_ATOMS)
        begin
            count_field = 16'($urandom_range(1, n_atoms - 1));
        end

        for (int k = 0; k < n_atoms; k++)
        begin
            a_type = ($urandom_range(0, 2) == 0) ? want_type : 16'($urandom);
            a_count = 16'($urandom);
            a_len = 2 + $urandom_range(0, 10);
            if (k == bad_atom && shape == SHAPE_SHORT_ATOM)
                a_len = $urandom_range(0, 1);
            if (k == bad_atom && shape == SHAPE_HUGE_ATOM)
                a_len = $urandom | 32'h0001_0000;
            atom_hdr = {a_len, a_count, a_type};
            crc = 16'h0;
            for (int j = 0; j < 8; j++)
            begin
                d = atom_hdr[8 * j +: 8];
                crc = crc16_arc_step(crc, d);
                body.push_back(d);
            end
            if (k == bad_atom && shape == SHAPE_SHORT_ATOM)
                break;
            if (k == bad_atom && shape == SHAPE_HUGE_ATOM)
            begin
                n = $urandom_range(0, 6);
                repeat (n) body.push_back(8'($urandom));
                break;
            end
            for (int j = 0; j < a_len - 2; j++)
            begin
                d = 8'($urandom);
                crc = crc16_arc_step(crc, d);
                body.push_back(d);
            end
            if (k == bad_atom && shape == SHAPE_BAD_CRC)
                crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            body.push_back(crc[7:0]);
            body.push_back(crc[15:8]);
        end

        total = SIGNATURE_BYTES + 8 + body.size();
        if (shape == SHAPE_OVERFLOW)
            total = $urandom_range(0, total - 1);
        else if ($urandom_range(0, 1) == 1)
            total = total + $urandom_range(1, 1000);

        for (int j = 0; j < SIGNATURE_BYTES; j++)
        begin
            d = sig_word[8 * (j % 4) +: 8];
            if (shape == SHAPE_BAD_SIGNATURE && j == bad_pos)
                d = d ^ 8'($urandom_range(1, 255));
            push_item(d, j == 0);
        end
        push_item(8'($urandom), 1'b0);
        push_item(8'($urandom), 1'b0);
        push_item(count_field[7:0], 1'b0);
        push_item(count_field[15:8], 1'b0);
        for (int j = 0; j < 4; j++)
            push_item(total[8 * j +: 8], 1'b0);
        foreach (body[j])
            push_item(body[j], 1'b0);
        n = $urandom_range(0, 2);
        repeat (n) push_item(8'($urandom), 1'b0);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        if (idx == CFG_WANTED_TYPE)
            want_type = value[15:0];
        else
            sig_word = value;
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", field, got, want));
    endtask

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin : byte_driver
        image_byte_t item;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                walk_image_byte(data_byte, first_byte);
                bytes_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    item = pending_bytes.pop_front();
                    data_byte <= item.value;
                    first_byte <= item.first;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result of kind %0d", result_kind));
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("result_kind", 32'(result_kind), 32'(want.kind));
                    compare_field("atom_type", 32'(atom_type), 32'(want.atom_type));
                    compare_field("atom_count", 32'(atom_count), 32'(want.atom_count));
                    compare_field("data_length", data_length, want.data_length);
                    compare_field("computed_crc", 32'(computed_crc), 32'(want.computed_crc));
                    compare_field("stored_crc", 32'(stored_crc), 32'(want.stored_crc));
                    compare_field("type_match", 32'(type_match), 32'(want.type_match));
                    compare_field("final_res", 32'(final_res), 32'(want.final_res));
                end
            end
            out_stall <= long_hold || ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // Holds the result side off for a long stretch so the result queue fills and the
    // byte channel backs up.
    initial
    begin
        while (bytes_accepted < HOLD_START)
            @(posedge clk);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("eeprom_atom_table_checker_tb: FAIL");
        $finish;
    end

    initial
    begin
        int phase_end;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 7;
        receiver_idle_pct = 75;
        write_register(CFG_WANTED_TYPE, 32'h0000_FFFF);
        write_register(CFG_SIGNATURE_WORD, 32'hFFFF_FFFF);

        push_item(8'h5A, 1'b0);
        push_item(8'h00, 1'b1);
        push_item(8'hFF, 1'b0);
        for (int j = 0; j < SIGNATURE_BYTES; j++)
            push_item(8'hFF, j == 0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        repeat (4) push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b0);

        for (int ph = 0; ph < 3; ph++)
        begin
            wait_until_drained();
            case (ph)
                0:
                begin
                    write_register(CFG_WANTED_TYPE, $urandom);
                    write_register(CFG_SIGNATURE_WORD, $urandom);
                end
                1:
                begin
                    sender_idle_pct = 75;
                    receiver_idle_pct = 7;
                    write_register(CFG_WANTED_TYPE, 32'h0);
                    write_register(CFG_SIGNATURE_WORD, 32'h0);
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                    write_register(CFG_WANTED_TYPE, $urandom);
                    write_register(CFG_SIGNATURE_WORD, $urandom);
                end
            endcase
            phase_end = queued_total + PHASE_BYTES;
            while (queued_total < phase_end)
                queue_random_image();
        end

        wait_until_drained();
        if (error_count == 0)
            $display("eeprom_atom_table_checker_tb: PASS");
        else
            $display("eeprom_atom_table_checker_tb: FAIL");
        $finish;
    end

endmodule
